// ===== sv/bvse_pkg.sv =====
// Shared types, constants and the LiPo discharge curve for the battery
// voltage and state-of-charge estimator. No dependencies.
package bvse_pkg;

   localparam int BVSE_BURST_MAX_DEF = 16;

   localparam int RAW_W     = 12;
   localparam int MV_W      = 13;
   localparam int PCT_W     = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam int CODE_MAX     = 4095;
   localparam int CODE_SHIFT   = 12;
   localparam int EMA_SHIFT    = 3;
   localparam int THRESH_RESET = 2500;
   localparam int FSCALE_RESET = 3300;

   localparam int CURVE_POINTS = 17;
   localparam int SEG_W        = 5;
   localparam int SPAN_W       = 9;
   localparam int STEP_W       = 4;
   localparam int PCT_FULL     = 100;

   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd3270, 13'd3600, 13'd3700, 13'd3730, 13'd3750, 13'd3770, 13'd3790, 13'd3820,
      13'd3850, 13'd3870, 13'd3910, 13'd3950, 13'd3990, 13'd4060, 13'd4110, 13'd4160,
      13'd4200
   };
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd0, 7'd5, 7'd12, 7'd20, 7'd28, 7'd34, 7'd40, 7'd47, 7'd55, 7'd62, 7'd70, 7'd77,
      7'd83, 7'd90, 7'd94, 7'd98, 7'd100
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_THRESHOLD  = 1'b0,
      CSR_FULL_SCALE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_AVG_DIV,
      ST_SCALE_Q,
      ST_SCALE_FIX,
      ST_EMA,
      ST_SEARCH,
      ST_PCT_DIV
   } state_type;

   typedef struct packed {
      logic accum;
      logic clear_burst;
      logic avg_start;
      logic mul_load;
      logic scale_q;
      logic scale_fix;
      logic ema;
      logic seg_clear;
      logic seg_step;
      logic pct_start;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic good_zero;
      logic div_done;
      logic seg_advance;
      logic rsp_free;
   } status_type;

endpackage

// ===== sv/bvse_div.sv =====
// Restoring divider, one quotient bit per cycle; done holds until the next start.
// No dependencies; used by the estimator datapath.
module bvse_div #(
   parameter int DVD_W = 16,
   parameter int DVS_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== sv/bvse_datapath.sv =====
// Datapath of the estimator: burst accumulation, scaling, filter, curve
// search and interpolation, result register. Uses bvse_pkg and bvse_div.
module bvse_datapath import bvse_pkg::*; #(
   parameter int BURST_MAX = BVSE_BURST_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RAW_W-1:0]      raw_sample,
   input  logic                  read_ok,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [MV_W-1:0]       battery_mv,
   output logic [PCT_W-1:0]      charge_percent,
   output logic                  battery_present
);
   localparam int SUM_W = $clog2(CODE_MAX * BURST_MAX + 1);
   localparam int CNT_W = $clog2(BURST_MAX + 1);
   localparam int DVD_W = SUM_W;
   localparam int DVS_W = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;
   localparam int PROD_W = 2 * RAW_W;
   localparam int Q0_W = RAW_W + 1;

   logic [MV_W-1:0]   thr_ff, thr_in;
   logic [RAW_W-1:0]  fs_ff, fs_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  good_ff, good_in;
   logic [CNT_W-1:0]  burst_ff, burst_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [Q0_W-1:0]   q0_ff, q0_in;
   logic [MV_W-1:0]   smp_ff, smp_in;
   logic [MV_W-1:0]   filt_ff, filt_in;
   logic              fvalid_ff, fvalid_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]   rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;
   logic              rsp_present_ff, rsp_present_in;

   logic [DVD_W-1:0]  div_dividend;
   logic [DVS_W-1:0]  div_divisor;
   logic [DVD_W-1:0]  div_quotient;
   logic              div_done;
   logic              div_start;

   logic [SEG_W-1:0]  seg_prev;
   logic [MV_W-1:0]   seg_span;
   logic [MV_W-1:0]   seg_off;
   logic [PCT_W-1:0]  seg_step;
   logic [SPAN_W+STEP_W-1:0] interp_num;
   logic [PROD_W:0]   q0_sum;
   logic [PROD_W:0]   fix_rem;
   logic [RAW_W-1:0]  node_mv;
   logic [MV_W-1:0]   ema_delta;
   logic              present;
   logic [PCT_W-1:0]  pct_value;
   logic              seg_last;

   // Curve segment operands: seg_ff points at the first knee above the voltage.
   assign seg_prev   = seg_ff - 1'b1;
   assign seg_span   = CURVE_MV[seg_ff] - CURVE_MV[seg_prev];
   assign seg_off    = filt_ff - CURVE_MV[seg_prev];
   assign seg_step   = CURVE_PCT[seg_ff] - CURVE_PCT[seg_prev];
   assign interp_num = seg_off[SPAN_W-1:0] * seg_step[STEP_W-1:0];
   assign seg_last   = seg_ff == SEG_W'(CURVE_POINTS - 1);

   assign div_start    = cmd.avg_start | cmd.pct_start;
   assign div_dividend = cmd.avg_start ? sum_ff : DVD_W'(interp_num[RAW_W-1:0]);
   assign div_divisor  = cmd.avg_start ? DVS_W'(good_ff) : DVS_W'(seg_span[SPAN_W-1:0]);

   bvse_div #(
      .DVD_W(DVD_W),
      .DVS_W(DVS_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quotient),
      .done    (div_done)
   );

   // Division by 4095: estimate with p + p/4096, then one correction step.
   assign q0_sum  = {1'b0, prod_ff} + (PROD_W + 1)'(prod_ff >> CODE_SHIFT);
   assign fix_rem = {1'b0, prod_ff} - ((PROD_W + 1)'(q0_ff) << CODE_SHIFT)
                    + (PROD_W + 1)'(q0_ff);
   assign node_mv = (fix_rem >= (PROD_W + 1)'(CODE_MAX)) ? RAW_W'(q0_ff + 1'b1)
                                                          : q0_ff[RAW_W-1:0];
   assign ema_delta = (smp_ff >= filt_ff) ? ((smp_ff - filt_ff) >> EMA_SHIFT)
                                          : ((filt_ff - smp_ff) >> EMA_SHIFT);

   assign present = fvalid_ff && (filt_ff >= thr_ff);

   always_comb begin
      if (filt_ff <= CURVE_MV[0]) begin
         pct_value = '0;
      end else if (filt_ff >= CURVE_MV[CURVE_POINTS-1]) begin
         pct_value = PCT_W'(PCT_FULL);
      end else begin
         pct_value = CURVE_PCT[seg_prev] + div_quotient[PCT_W-1:0];
      end
   end

   always_comb begin
      thr_in         = thr_ff;
      fs_in          = fs_ff;
      sum_in         = sum_ff;
      good_in        = good_ff;
      burst_in       = burst_ff;
      prod_in        = prod_ff;
      q0_in          = q0_ff;
      smp_in         = smp_ff;
      filt_in        = filt_ff;
      fvalid_in      = fvalid_ff;
      seg_in         = seg_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_mv_in      = rsp_mv_ff;
      rsp_pct_in     = rsp_pct_ff;
      rsp_present_in = rsp_present_ff;

      if (csr_wr_en) begin
         case (csr_addr)
            CSR_THRESHOLD:  thr_in = csr_wdata;
            CSR_FULL_SCALE: fs_in  = csr_wdata[RAW_W-1:0];
            default: ;
         endcase
      end

      // Samples past the burst limit are dropped, but their last mark counts.
      if (cmd.accum && (burst_ff < CNT_W'(BURST_MAX))) begin
         burst_in = burst_ff + 1'b1;
         if (read_ok) begin
            sum_in  = sum_ff + SUM_W'(raw_sample);
            good_in = good_ff + 1'b1;
         end
      end
      if (cmd.clear_burst) begin
         sum_in   = '0;
         good_in  = '0;
         burst_in = '0;
      end

      if (cmd.mul_load) begin
         prod_in = div_quotient[RAW_W-1:0] * fs_ff;
      end
      if (cmd.scale_q) begin
         q0_in = q0_sum[CODE_SHIFT +: Q0_W];
      end
      if (cmd.scale_fix) begin
         smp_in = {node_mv, 1'b0};
      end
      if (cmd.ema) begin
         fvalid_in = 1'b1;
         if (!fvalid_ff) begin
            filt_in = smp_ff;
         end else if (smp_ff >= filt_ff) begin
            filt_in = filt_ff + ema_delta;
         end else begin
            filt_in = filt_ff - ema_delta;
         end
      end

      if (cmd.seg_clear) begin
         seg_in = SEG_W'(1);
      end else if (cmd.seg_step) begin
         seg_in = seg_ff + 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_mv_in      = present ? filt_ff : '0;
         rsp_pct_in     = present ? pct_value : '0;
         rsp_present_in = present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= MV_W'(THRESH_RESET);
         fs_ff        <= RAW_W'(FSCALE_RESET);
         sum_ff       <= '0;
         good_ff      <= '0;
         burst_ff     <= '0;
         filt_ff      <= '0;
         fvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         fs_ff        <= fs_in;
         sum_ff       <= sum_in;
         good_ff      <= good_in;
         burst_ff     <= burst_in;
         filt_ff      <= filt_in;
         fvalid_ff    <= fvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff        <= prod_in;
      q0_ff          <= q0_in;
      smp_ff         <= smp_in;
      seg_ff         <= seg_in;
      rsp_mv_ff      <= rsp_mv_in;
      rsp_pct_ff     <= rsp_pct_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign status.good_zero   = good_ff == '0;
   assign status.div_done    = div_done;
   assign status.seg_advance = !seg_last && (filt_ff >= CURVE_MV[seg_ff]);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_valid       = rsp_valid_ff;
   assign battery_mv      = rsp_mv_ff;
   assign charge_percent  = rsp_pct_ff;
   assign battery_present = rsp_present_ff;

endmodule

// ===== sv/bvse_ctrl.sv =====
// Sequencer of the estimator: walks one burst end through division,
// scaling, filter update, curve search and interpolation. Uses bvse_pkg.
module bvse_ctrl import bvse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accum = 1'b1;
               if (req_tlast) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.clear_burst = 1'b1;
            if (status.good_zero) begin
               cmd.seg_clear = 1'b1;
               state_in      = ST_SEARCH;
            end else begin
               cmd.avg_start = 1'b1;
               state_in      = ST_AVG_DIV;
            end
         end
         ST_AVG_DIV: begin
            if (status.div_done) begin
               cmd.mul_load = 1'b1;
               state_in     = ST_SCALE_Q;
            end
         end
         ST_SCALE_Q: begin
            cmd.scale_q = 1'b1;
            state_in    = ST_SCALE_FIX;
         end
         ST_SCALE_FIX: begin
            cmd.scale_fix = 1'b1;
            state_in      = ST_EMA;
         end
         ST_EMA: begin
            cmd.ema       = 1'b1;
            cmd.seg_clear = 1'b1;
            state_in      = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.seg_advance) begin
               cmd.seg_step = 1'b1;
            end else begin
               cmd.pct_start = 1'b1;
               state_in      = ST_PCT_DIV;
            end
         end
         ST_PCT_DIV: begin
            if (status.div_done && status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/battery_voltage_soc_estimator_core.sv =====
// Top level of the battery voltage and state-of-charge estimator.
// Depends on bvse_pkg, bvse_ctrl, bvse_datapath and bvse_div.
//
//   Channel  Direction  Beat contents
//   req_     in         tdata: raw_sample; tuser: read_ok; tlast: last_in_burst
//   rsp_     out        tdata: battery_mv, charge_percent; tuser: battery_present
//   csr_     in         write enable, register index, write data
//
// A sample beat that does not end a burst is taken back to back.
// A beat with tlast starts the burst-end sequence: a check of the good count,
// the average division (one quotient bit per cycle in the shared divider),
// scaling and filter update, the curve search, and the interpolation division
// in the same divider. req_tready is low during that sequence. A burst without
// a good sample skips the average division, scaling and filter.
// The result sits in an output register; while it waits on rsp_tready the
// next burst is already being accumulated. A held result only stalls the
// block at the final load of the following burst.
// Reset is synchronous and active high; it restores the register defaults
// (threshold 2500 mV, full scale 3300 mV) and clears the filter.
module battery_voltage_soc_estimator_core import bvse_pkg::*; #(
   parameter int BURST_MAX = BVSE_BURST_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] raw_sample, rest zero
   input  logic                  req_tuser,   // [0] read_ok
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [12:0] battery_mv, [19:13] charge_percent
   output logic                  rsp_tuser,   // [0] battery_present
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cmd_type          cmd;
   status_type       status;
   logic [MV_W-1:0]  battery_mv;
   logic [PCT_W-1:0] charge_percent;

   bvse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tlast (req_tlast),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath only sees the sample fields; beat acceptance is the sequencer's.
   bvse_datapath #(
      .BURST_MAX(BURST_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .raw_sample     (req_tdata[RAW_W-1:0]),
      .read_ok        (req_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .battery_mv     (battery_mv),
      .charge_percent (charge_percent),
      .battery_present(rsp_tuser)
   );

   assign rsp_tdata = {(RSP_DATA_W - MV_W - PCT_W)'(0), charge_percent, battery_mv};

endmodule

// ===== sv/bvse_checker.sv =====
// Port-level checks for the estimator top level, attached by bind.
// Depends on bvse_pkg.
module bvse_checker import bvse_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // The sampling side only closes after a beat that ends a burst.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tlast))
      else $error("sample side stalled without a burst end");

   // An absent battery reports zero voltage and zero charge.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("absent battery with nonzero result");

   // At or above the top of the curve the charge is full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && (rsp_tdata[MV_W-1:0] >= CURVE_MV[CURVE_POINTS-1])
      |-> rsp_tdata[MV_W +: PCT_W] == PCT_W'(PCT_FULL))
      else $error("full voltage without full charge");

endmodule

bind battery_voltage_soc_estimator_core bvse_checker u_checker (.*);

// ===== tb/sv/battery_voltage_soc_estimator_core_tb.sv =====
// Self-checking testbench for battery_voltage_soc_estimator_core: drives sample
// bursts, predicts each burst-end reading and checks every result beat.
// Depends on bvse_pkg and battery_voltage_soc_estimator_core.
`timescale 1ns / 1ps

module battery_voltage_soc_estimator_core_tb;
   import bvse_pkg::*;

   localparam int BURST_LIMIT  = BVSE_BURST_MAX_DEF;
   // This pause covers any burst-end work still in flight when the queue runs dry.
   localparam int DRAIN_CYCLES = 150;
   // Longest correct stretch without any beat is the deliberate receiver
   // hold-off below; the watchdog limit is several times that.
   localparam int HOLD_CYCLES  = 3000;
   localparam int STALL_LIMIT  = 20000;
   localparam int EMA_DIVISOR  = 8;
   localparam int PCT_LSB      = MV_W;

   // LiPo discharge curve knees, millivolts and percent.
   localparam int unsigned KNEE_MV [CURVE_POINTS] = '{
      3270, 3600, 3700, 3730, 3750, 3770, 3790, 3820, 3850,
      3870, 3910, 3950, 3990, 4060, 4110, 4160, 4200
   };
   localparam int unsigned KNEE_PCT [CURVE_POINTS] = '{
      0, 5, 12, 20, 28, 34, 40, 47, 55, 62, 70, 77, 83, 90, 94, 98, 100
   };

   typedef struct {
      logic [MV_W-1:0]  mv;
      logic [PCT_W-1:0] pct;
      logic             present;
   } soc_reading_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [11:0] raw_sample, rest zero
   logic                  req_tuser;   // [0] read_ok
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [12:0] battery_mv, [19:13] charge_percent
   logic                  rsp_tuser;   // [0] battery_present
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow of the block: registers, burst accumulator and the filter.
   logic [MV_W-1:0]  threshold_mv;
   logic [RAW_W-1:0] full_scale_mv;
   logic [15:0]      burst_sum;
   logic [4:0]       good_samples;
   logic [4:0]       burst_samples;
   logic [MV_W-1:0]  ema_mv;
   logic             ema_valid;

   soc_reading_type pending_readings[$];

   int error_count   = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   battery_voltage_soc_estimator_core #(
      .BURST_MAX(BURST_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // State of charge from the curve: linear interpolation between the two
   // surrounding knees, truncated; clamped to 0 and 100 outside the curve.
   function automatic int unsigned percent_from_mv(input int unsigned mv);
      int unsigned k;
      if (mv <= KNEE_MV[0]) return 0;
      if (mv >= KNEE_MV[CURVE_POINTS-1]) return PCT_FULL;
      for (k = 1; k < CURVE_POINTS; k++) begin
         if (mv < KNEE_MV[k]) begin
            return KNEE_PCT[k-1] + (mv - KNEE_MV[k-1]) * (KNEE_PCT[k] - KNEE_PCT[k-1])
                   / (KNEE_MV[k] - KNEE_MV[k-1]);
         end
      end
      return PCT_FULL;
   endfunction

   // Applies one accepted sample beat to the shadow state; a beat that ends
   // a burst queues the reading the block must report for it.
   function automatic void predict_sample(input logic [RAW_W-1:0] raw, input logic ok,
                                          input logic last);
      int unsigned  avg;
      int unsigned  node_mv;
      logic [MV_W-1:0] scaled_mv;
      soc_reading_type reading;
      // Samples past the burst limit are dropped, but their end mark counts.
      if (burst_samples < BURST_LIMIT) begin
         burst_samples++;
         if (ok) begin
            burst_sum = burst_sum + raw;
            good_samples++;
         end
      end
      if (!last) return;
      // A burst without a good sample leaves the filter alone.
      if (good_samples != 0) begin
         avg       = burst_sum / good_samples;
         node_mv   = avg * full_scale_mv / CODE_MAX;
         scaled_mv = MV_W'(node_mv * 2);   // 2:1 divider in front of the ADC
         if (!ema_valid)
            ema_mv = scaled_mv;
         else if (scaled_mv >= ema_mv)
            ema_mv = ema_mv + (scaled_mv - ema_mv) / EMA_DIVISOR;
         else
            ema_mv = ema_mv - (ema_mv - scaled_mv) / EMA_DIVISOR;
         ema_valid = 1'b1;
      end
      burst_sum     = '0;
      good_samples  = '0;
      burst_samples = '0;
      reading.present = ema_valid && (ema_mv >= threshold_mv);
      reading.mv      = reading.present ? ema_mv : '0;
      reading.pct     = reading.present ? PCT_W'(percent_from_mv(ema_mv)) : '0;
      pending_readings.push_back(reading);
   endfunction

   // Inputs are sampled at the edge before any update of this step lands, so
   // the values seen here are the ones the handshake moved.
   always @(posedge clock) begin : soc_predictor
      if (reset) begin
         threshold_mv  = MV_W'(THRESH_RESET);
         full_scale_mv = RAW_W'(FSCALE_RESET);
         burst_sum     = '0;
         good_samples  = '0;
         burst_samples = '0;
         ema_mv        = '0;
         ema_valid     = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_THRESHOLD:  threshold_mv  = csr_wdata;
               CSR_FULL_SCALE: full_scale_mv = csr_wdata[RAW_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_sample(req_tdata[RAW_W-1:0], req_tuser, req_tlast);
      end
   end

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic note_mismatch(input string what);
      error_count++;
      if (error_count <= 10) $display("%0t ns: %s", $time, what);
   endtask

   always @(posedge clock) begin : reading_checker
      soc_reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing pending: mv %0d pct %0d present %0b",
                                    rsp_tdata[MV_W-1:0], rsp_tdata[PCT_LSB +: PCT_W], rsp_tuser));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[MV_W-1:0] !== want.mv)
               note_mismatch($sformatf("battery_mv: expected %0d, got %0d",
                                       want.mv, rsp_tdata[MV_W-1:0]));
            if (rsp_tdata[PCT_LSB +: PCT_W] !== want.pct)
               note_mismatch($sformatf("charge_percent: expected %0d, got %0d",
                                       want.pct, rsp_tdata[PCT_LSB +: PCT_W]));
            if (rsp_tuser !== want.present)
               note_mismatch($sformatf("battery_present: expected %0b, got %0b",
                                       want.present, rsp_tuser));
         end
      end
   end

   // Ends the run if no beat moves on any port for too long.
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side. A requested hold-off keeps tready low until hold_left, counted
   // down here, runs out; otherwise tready stalls at the phase's rate.
   always @(posedge clock) begin : result_sink
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic logic [RAW_W-1:0] clamp_code(input int code);
      if (code < 0) return '0;
      if (code > CODE_MAX) return RAW_W'(CODE_MAX);
      return RAW_W'(code);
   endfunction

   // Offers one sample beat, after a random gap at the phase's idle rate, and
   // returns at the edge that accepted it. tvalid stays high into the next
   // beat unless that beat starts with a gap.
   task automatic push_sample(input logic [RAW_W-1:0] raw, input logic ok, input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-RAW_W){1'b0}}, raw};
      req_tuser  <= ok;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // One burst around a center code with a little jitter and some wild codes.
   task automatic send_burst(input int center, input int len, input int ok_pct);
      int k;
      int code;
      for (k = 0; k < len; k++) begin
         if ($urandom_range(99) < 20)
            code = $urandom_range(0, CODE_MAX);
         else
            code = center + int'($urandom_range(0, 64)) - 32;
         push_sample(clamp_code(code), ($urandom_range(99) < ok_pct), k == len - 1);
      end
   endtask

   // Stops offering and waits until every reading has come back and the block
   // has had time to finish anything still in progress.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_register(input csr_index_type idx, input int value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Reset defaults, empty bursts before and after the filter is loaded,
   // full-range codes, an overlong burst and a mixed good/bad burst.
   task automatic test_directed_cases();
      int k;
      send_idle_pct = 0;
      stall_pct     = 0;
      // Empty burst with the filter not yet loaded: all zero.
      push_sample(CODE_MAX, 1'b0, 1'b1);
      // Top code loads the filter at 6600 mV, 100 percent.
      push_sample(CODE_MAX, 1'b1, 1'b1);
      // Zero code pulls the filter down by one eighth of the gap.
      push_sample('0, 1'b1, 1'b1);
      // Overlong burst: the trailing top codes must be ignored.
      for (k = 0; k < BURST_LIMIT; k++) push_sample(12'd2000, 1'b1, 1'b0);
      push_sample(CODE_MAX, 1'b1, 1'b0);
      push_sample(CODE_MAX, 1'b1, 1'b1);
      // Bad samples stay out of the average.
      push_sample(12'd1000, 1'b0, 1'b0);
      push_sample(12'd2300, 1'b1, 1'b0);
      push_sample(12'd2310, 1'b1, 1'b1);
      // Empty burst with a loaded filter reports the unchanged value.
      push_sample(12'd123, 1'b0, 1'b1);
      settle();
   endtask

   // Both registers at their extremes: zero threshold, a threshold equal to the top
   // reading (battery absent below it), zero full scale and the smallest nonzero one.
   task automatic test_register_extremes();
      int thresholds  [6] = '{0, 6600, 2500, 0, 3270, 0};
      int full_scales [6] = '{3300, 3300, 0, 0, 1, 0};
      int s;
      int b;
      send_idle_pct = 25;
      stall_pct     = 25;
      thresholds[5]  = $urandom_range(0, 6600);
      full_scales[5] = $urandom_range(0, 3300);
      for (s = 0; s < 6; s++) begin
         write_register(CSR_THRESHOLD, thresholds[s]);
         write_register(CSR_FULL_SCALE, full_scales[s]);
         for (b = 0; b < 3; b++)
            send_burst($urandom_range(1500, CODE_MAX), $urandom_range(1, BURST_LIMIT), 90);
         settle();
      end
      write_register(CSR_THRESHOLD, THRESH_RESET);
      write_register(CSR_FULL_SCALE, FSCALE_RESET);
   endtask

   // The result side holds off for a long stretch while bursts keep coming,
   // so the output register fills and the block has to stall its input.
   task automatic test_backpressure();
      int b;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HOLD_CYCLES;
      for (b = 0; b < 5; b++) send_burst($urandom_range(2000, 2650), 6, 100);
      settle();
   endtask

   // Random bursts with a drifting center code, so the filter wanders across
   // the whole curve, plus jumps, single-sample, overlong and all-bad bursts.
   task automatic run_traffic_phase(input int idle_pct, input int stall, input int n_items);
      int sent;
      int len;
      int pick;
      int center;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      sent   = 0;
      center = $urandom_range(2100, 2600);
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 10)
            center = $urandom_range(0, CODE_MAX);
         else if (pick < 40)
            center = $urandom_range(1900, 2750);
         else
            center = clamp_code(center + int'($urandom_range(0, 80)) - 40);
         pick = $urandom_range(99);
         if (pick < 5)
            len = $urandom_range(BURST_LIMIT + 1, BURST_LIMIT + 4);
         else if (pick < 15)
            len = 1;
         else
            len = $urandom_range(2, BURST_LIMIT);
         send_burst(center, len, ($urandom_range(99) < 5) ? 0 : 85);
         sent += (len > BURST_LIMIT) ? BURST_LIMIT : len;
      end
      settle();
   endtask

   // Four idling phases; new random register values between them, mostly in
   // the range where the filtered voltage lands on the curve.
   task automatic test_random_traffic();
      int idle_pcts  [4] = '{0, 75, 0, 25};
      int stall_pcts [4] = '{0, 0, 75, 25};
      int p;
      for (p = 0; p < 4; p++) begin
         write_register(CSR_THRESHOLD, ($urandom_range(99) < 80) ?
                        $urandom_range(0, 3800) : $urandom_range(0, 6600));
         write_register(CSR_FULL_SCALE, ($urandom_range(99) < 80) ?
                        $urandom_range(3000, 3300) : $urandom_range(0, 3300));
         run_traffic_phase(idle_pcts[p], stall_pcts[p], 310);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_addr   <= CSR_THRESHOLD;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      if (error_count == 0 && pending_readings.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
